/* design/assert_macros.svh */
// assertion macros used by the framer parse module
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define FTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is held
`define FTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ftf_pkg.sv */
// types and constants of the fieldbus telegram framer
// no dependencies; imported by every framer module
`default_nettype none

package ftf_pkg;

	// start delimiters and end byte
	localparam logic [7:0] BYTE_SC  = 8'hE5;
	localparam logic [7:0] BYTE_SD1 = 8'h10;
	localparam logic [7:0] BYTE_SD2 = 8'h68;
	localparam logic [7:0] BYTE_SD3 = 8'hA2;
	localparam logic [7:0] BYTE_SD4 = 8'hDC;
	localparam logic [7:0] BYTE_END = 8'h16;

	// variable telegram length limits
	localparam logic [7:0] VAR_MIN_LEN = 8'd4;
	localparam logic [7:0] VAR_MAX_LEN = 8'd249;

	// telegram geometry
	localparam int FIXED11_TOTAL = 14;
	localparam int FIXED3_FIRST  = 2;
	localparam int FIXED3_LAST   = 4;
	localparam int FIXED11_FIRST = 2;
	localparam int FIXED11_LAST  = FIXED11_TOTAL - 2;
	localparam int VAR_FIRST     = 5;
	localparam int VAR_DATA_OFS  = 4;
	localparam int LEN1_POS      = 2;
	localparam int LEN2_POS      = 3;
	localparam int TOKEN_LAST    = 3;

	localparam int POS_W = 9;

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_OK       = 3'd1,
		ST_EXTRA    = 3'd2,
		ST_LONG     = 3'd3,
		ST_SHORT    = 3'd4,
		ST_WRONGEND = 3'd5,
		ST_LENMIS   = 3'd6,
		ST_CSUM     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		KIND_SC  = 3'd0,
		KIND_SD1 = 3'd1,
		KIND_SD2 = 3'd2,
		KIND_SD3 = 3'd3,
		KIND_SD4 = 3'd4
	} kind_t;

	// one result item
	typedef struct packed {
		status_t            status;
		kind_t              kind;
		logic [POS_W-1:0]   pos;
		logic               frame_end;
	} result_t;

endpackage

`default_nettype wire

/* design/ftf_in_stage.sv */
// input register of the framer: holds one received byte
// depends on ftf_pkg only through the common import style
`default_nettype none

module ftf_in_stage
	import ftf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       room,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// stall only while a held byte cannot move on
	assign in_stall = valid_s1 && !room;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

/* design/ftf_parse.sv */
// framing state and per-byte decision logic
// depends on ftf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ftf_parse
	import ftf_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] byte_s1,
	output result_t         res
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

	typedef struct packed {
		status_t    status;
		logic       done;
		logic [7:0] sum;
	} body_t;

	logic [CW-1:0] cnt_q;
	kind_t         kind_q;
	logic [7:0]    sum_q;
	logic [7:0]    len_first_q;
	logic [7:0]    data_len_q;

	logic [CW-1:0] cnt_n;
	kind_t         kind_n;
	logic [7:0]    sum_n;
	logic [7:0]    len_first_n;
	logic [7:0]    data_len_n;
	logic [CW-1:0] pos_full;
	body_t         body;

	// checksummed body: data first..last, checksum at last+1, end byte at last+2
	function automatic body_t body_byte(
		input logic [CW-1:0] pos,
		input logic [7:0]    b,
		input logic [CW-1:0] first,
		input logic [CW-1:0] last,
		input logic [7:0]    sum
	);
		body_t r;
		r.status = ST_BUSY;
		r.done   = 1'b0;
		r.sum    = sum;
		if (pos >= first && pos <= last) begin
			r.sum = sum + b;
		end else if (pos == last + CW'(1)) begin
			r.sum = sum - b;
		end else if (pos == last + CW'(2)) begin
			r.done = 1'b1;
			if (b != BYTE_END) begin
				r.status = ST_WRONGEND;
			end else if (sum != 8'd0) begin
				r.status = ST_CSUM;
			end else begin
				r.status = ST_OK;
			end
		end
		return r;
	endfunction

	assign pos_full = cnt_q + CW'(1);

	// body check, with the data window chosen by frame kind
	always_comb begin
		unique case (kind_q)
			KIND_SD1: body = body_byte(pos_full, byte_s1, CW'(FIXED3_FIRST),
				CW'(FIXED3_LAST), sum_q);
			KIND_SD3: body = body_byte(pos_full, byte_s1, CW'(FIXED11_FIRST),
				CW'(FIXED11_LAST), sum_q);
			default:  body = body_byte(pos_full, byte_s1, CW'(VAR_FIRST),
				CW'(data_len_q) + CW'(VAR_DATA_OFS), sum_q);
		endcase
	end

	// next state and result for the byte in the input register
	always_comb begin
		cnt_n         = cnt_q;
		kind_n        = kind_q;
		sum_n         = sum_q;
		len_first_n   = len_first_q;
		data_len_n    = data_len_q;
		res.status    = ST_BUSY;
		res.frame_end = 1'b0;
		if (cnt_q >= CW'(MAX_FRAME_BYTES)) begin
			res.status    = ST_LONG;
			res.frame_end = 1'b1;
		end else begin
			cnt_n = pos_full;
			if (pos_full == CW'(1)) begin
				sum_n = 8'd0;
				unique case (byte_s1)
					BYTE_SC: begin
						kind_n        = KIND_SC;
						res.status    = ST_OK;
						res.frame_end = 1'b1;
					end
					BYTE_SD1: kind_n = KIND_SD1;
					BYTE_SD2: kind_n = KIND_SD2;
					BYTE_SD3: kind_n = KIND_SD3;
					BYTE_SD4: kind_n = KIND_SD4;
					default: begin
						kind_n        = KIND_SC;
						res.status    = ST_EXTRA;
						res.frame_end = 1'b1;
					end
				endcase
			end else begin
				unique case (kind_q)
					KIND_SD1, KIND_SD3: begin
						sum_n         = body.sum;
						res.status    = body.status;
						res.frame_end = body.done;
					end
					KIND_SD4: begin
						if (pos_full == CW'(TOKEN_LAST)) begin
							res.status    = ST_OK;
							res.frame_end = 1'b1;
						end
					end
					KIND_SD2: begin
						if (pos_full == CW'(LEN1_POS)) begin
							len_first_n = byte_s1;
						end else if (pos_full == CW'(LEN2_POS)) begin
							// mismatch first, then too short, then too long
							if (byte_s1 != len_first_q) begin
								res.status    = ST_LENMIS;
								res.frame_end = 1'b1;
							end else if (byte_s1 < VAR_MIN_LEN) begin
								res.status    = ST_SHORT;
								res.frame_end = 1'b1;
							end else if (byte_s1 > VAR_MAX_LEN) begin
								res.status    = ST_LONG;
								res.frame_end = 1'b1;
							end else begin
								data_len_n = byte_s1;
							end
						end else if (pos_full > CW'(VAR_DATA_OFS)) begin
							sum_n         = body.sum;
							res.status    = body.status;
							res.frame_end = body.done;
						end
					end
					default: begin
						res.status    = ST_EXTRA;
						res.frame_end = 1'b1;
					end
				endcase
			end
		end
		if (res.frame_end) begin
			cnt_n = '0;
		end
		res.kind = kind_n;
		res.pos  = pos_full[POS_W-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			kind_q <= KIND_SC;
			sum_q  <= 8'd0;
		end else if (take) begin
			cnt_q  <= cnt_n;
			kind_q <= kind_n;
			sum_q  <= sum_n;
		end
	end

	// length bytes, always written before use within a telegram
	always_ff @(posedge clk) begin
		if (take) begin
			len_first_q <= len_first_n;
			data_len_q  <= data_len_n;
		end
	end

	`FTF_ASSERT_NOW(a_end_matches_status, take,
		res.frame_end == (res.status != ST_BUSY), "frame end and status disagree")
	`FTF_ASSERT_NEXT(a_count_clears, take && res.frame_end,
		cnt_q == '0, "byte count not cleared after frame end")
	`FTF_ASSERT_NEXT(a_count_runs, take && !res.frame_end,
		cnt_q != '0, "byte count lost inside a frame")
	`FTF_ASSERT_NOW(a_count_bound, 1'b1,
		cnt_q <= CW'(MAX_FRAME_BYTES), "byte count beyond frame limit")

endmodule

`default_nettype wire

/* design/ftf_out_stage.sv */
// result register of the framer with its output handshake
// depends on ftf_pkg for the result type
`default_nettype none

module ftf_out_stage
	import ftf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     valid_s1,
	input  wire result_t  res,
	input  wire logic     out_stall,
	output logic          room,
	output logic          out_valid,
	output result_t       res_s2
);

	// register free, or being emptied this cycle
	assign room = !out_valid || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (room) begin
			out_valid <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (room && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

/* design/fieldbus_telegram_framer_unit.sv */
// Fieldbus telegram framer: takes received bytes and frames telegrams.
// Input channel in_valid/in_stall carries rx_byte, one byte per request.
// Output channel out_valid/out_stall carries one result per byte: status,
// frame_kind, byte_position and frame_end.
// A byte is first held in the input register; its result is then
// registered in the result register as the receiver makes room.
// Throughput: one byte per cycle unless the receiver stalls; the framing
// state is updated by a short per-byte decision between the input register
// and the result register. When the receiver stalls, the result register
// holds, and in_stall is raised while the input register holds a byte.
// Reset clears both registers' valid flags, the byte count, the frame kind
// and the checksum; the framer starts hunting for a start byte.
// MAX_FRAME_BYTES sets the width of the byte counter and the frame limit.
`default_nettype none

module fieldbus_telegram_framer_unit
	import ftf_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output logic [2:0]      frame_kind,
	output logic [8:0]      byte_position,
	output logic            frame_end
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       room;
	result_t    res;
	result_t    res_s2;

	// input register
	ftf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.room     (room),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// framing state and decision
	ftf_parse #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (valid_s1 && room),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	// result register
	ftf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_stall (out_stall),
		.room      (room),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	// result fields
	assign status        = res_s2.status;
	assign frame_kind    = res_s2.kind;
	assign byte_position = res_s2.pos;
	assign frame_end     = res_s2.frame_end;

endmodule

`default_nettype wire
